>>> src/perlin_noise_3d_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker.
`ifndef PERLIN_NOISE_3D_MACROS_SVH
`define PERLIN_NOISE_3D_MACROS_SVH
// implication checked on every edge outside reset
`define PN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication outside reset
`define PN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/pn3d_pkg.sv
// Types, constants and table functions for the 3D Perlin noise pipeline.
// Depends on nothing; used by the noise top level.
package pn3d_pkg;

   localparam int COORD_W = 32;
   localparam int OUT_W   = 20;
   localparam int OUT_FRAC = 16;
   // lattice period; the cell index is the low bits of the floor
   localparam int CELL_PERIOD = 256;

   // permutation table, one period
   function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
      logic [7:0] tbl [256];
      tbl = '{
         151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,8,99,37,
         240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,35,11,32,57,177,
         33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,134,139,48,27,166,77,146,
         158,231,83,111,229,122,60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,65,25,
         63,161,1,216,80,73,209,76,132,187,208,89,18,169,200,196,135,130,116,188,159,86,164,100,
         109,198,173,186,3,64,52,217,226,250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,
         59,227,47,16,58,17,182,189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,
         101,155,167,43,172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,
         246,97,228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,107,
         49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,
         93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180};
      return tbl[idx];
   endfunction

   // hash value modulo twelve, as a gradient index
   // quotient by reciprocal multiply (171/2048 is exact for 8-bit inputs)
   function automatic logic [3:0] grad_index(input logic [7:0] h);
      logic [15:0] p;
      logic [4:0]  q;
      p = 16'(h) * 16'd171;
      q = 5'(p >> 11);
      return 4'(h - 8'(8'(q) * 8'd12));
   endfunction

   // gradient code: {x_neg,x_on,y_neg,y_on,z_neg,z_on}
   function automatic logic [5:0] grad_lookup(input logic [3:0] g);
      logic [5:0] r;
      case (g)
         4'd0:    r = 6'b01_01_00;
         4'd1:    r = 6'b11_01_00;
         4'd2:    r = 6'b01_11_00;
         4'd3:    r = 6'b11_11_00;
         4'd4:    r = 6'b01_00_01;
         4'd5:    r = 6'b11_00_01;
         4'd6:    r = 6'b01_00_11;
         4'd7:    r = 6'b11_00_11;
         4'd8:    r = 6'b00_01_01;
         4'd9:    r = 6'b00_11_01;
         4'd10:   r = 6'b00_01_11;
         4'd11:   r = 6'b00_11_11;
         default: r = 6'b00_00_00;
      endcase
      return r;
   endfunction

endpackage

>>> src/pn3d_fmul.sv
// One pipelined fixed-point multiply with round-half-up back to FRAC_BITS.
// Depends on nothing; used by the noise top level.
module pn3d_fmul #(
   parameter int FRAC_BITS = 16,
   parameter int A_W = 24,
   parameter int B_W = 24,
   parameter int P_W = 24
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic signed [A_W-1:0] a_in,
   input  logic signed [B_W-1:0] b_in,
   output logic signed [P_W-1:0] p_out
);
   localparam int FULL_W = A_W + B_W;
   logic signed [FULL_W-1:0] prod;
   logic signed [FULL_W-1:0] rnd;

   // round to nearest, ties up, then register
   assign prod = FULL_W'(a_in) * FULL_W'(b_in);
   assign rnd  = (prod + (FULL_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (enable) begin
         p_out <= P_W'(rnd);
      end
   end
endmodule

>>> src/perlin_noise_3d.sv
// Top level of the 3D Perlin noise generator: a deep pipeline over
// floor/hash, corner dot products, fade polynomial and trilinear mix.
// Depends on pn3d_pkg and pn3d_fmul.
//
// Usage: a request on req_ carries a point (x, y, z) in signed fixed point
// with FRAC_BITS fraction bits; one noise sample in signed Q3.16 comes back
// on rsp_ per request, in request order. The cell period is 256.
// Throughput: one request per cycle when not stalled; every stage is a
// register with its own valid bit, and the whole pipe advances together.
// Stall: when rsp_tready is low and the output register holds a result, the
// whole pipe freezes and req_tready drops; bubbles inside the pipe are not
// squeezed out, they simply move along when the pipe advances.
// Reset: synchronous, active high; clears all valid bits, no result pending,
// and req_tready is low while reset is held.
// The hash chain runs through three table lookups, one per stage; the fade
// uses five multiplies over three stages; the mix uses three multiply levels.
module perlin_noise_3d #(
   parameter int FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: [31:0] coord_x, [63:32] coord_y, [95:64] coord_z
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: [19:0] noise_value, [23:20] zero
   output logic [23:0] rsp_tdata
);
   localparam int F    = FRAC_BITS;
   localparam int FW   = F + 2;          // signed value in [-1, 1]
   localparam int MW   = F + 5;          // fade intermediates, |v| < 16
   localparam int NW   = F + 3;          // dot products, |v| <= 2
   localparam int CB   = $clog2(pn3d_pkg::CELL_PERIOD);
   localparam int DEPTH = 13;
   localparam logic signed [MW-1:0] ONE_M = MW'(1) <<< F;

   // global advance: stall only when output is full and not taken
   logic adv;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   assign adv = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = adv && !reset;
   assign vld_in = {vld_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: split coordinates into cell and fraction
   logic [2:0][CB-1:0]  cell_ff;
   logic [2:0][F-1:0]   frac1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            cell_ff[i]  <= req_tdata[32*i+F +: CB];
            frac1_ff[i] <= req_tdata[32*i +: F];
         end
      end
   end

   // stage 2: first hash level on z and z+1
   logic [1:0][7:0]    hz_ff;
   logic [CB-1:0]      cx2_ff, cy2_ff;
   logic [2:0][F-1:0]  frac2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int b = 0; b < 2; b++) begin
            hz_ff[b] <= pn3d_pkg::perm_lookup(8'(9'(cell_ff[2]) + 9'(b)));
         end
         cx2_ff    <= cell_ff[0];
         cy2_ff    <= cell_ff[1];
         frac2_ff  <= frac1_ff;
      end
   end

   // stage 3: second hash level over y
   logic [3:0][7:0]   hy_ff;
   logic [CB-1:0]     cx3_ff;
   logic [2:0][F-1:0] frac3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            hy_ff[k] <= pn3d_pkg::perm_lookup(
               8'(10'(cy2_ff) + 10'(k & 1) + 10'(hz_ff[k >> 1])));
         end
         cx3_ff   <= cx2_ff;
         frac3_ff <= frac2_ff;
      end
   end

   // stage 4: third hash level over x, gradient pick
   logic [7:0][5:0]   gr_ff;
   logic [2:0][F-1:0] frac4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 8; k++) begin
            gr_ff[k] <= pn3d_pkg::grad_lookup(pn3d_pkg::grad_index(
               pn3d_pkg::perm_lookup(8'(10'(cx3_ff) + 10'(k & 1)
                  + 10'(hy_ff[((k >> 2) << 1) | ((k >> 1) & 1)])))));
         end
         frac4_ff <= frac3_ff;
      end
   end

   // stage 5: corner dot products
   logic signed [NW-1:0] dot_ff [8];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 8; k++) begin
            logic signed [NW-1:0] d [3];
            logic signed [NW-1:0] s;
            s = '0;
            for (int a = 0; a < 3; a++) begin
               d[a] = $signed(NW'({1'b0, frac4_ff[a]})) - (((k >> a) & 1) != 0
                      ? (NW'(1) <<< F) : NW'(0));
               if (gr_ff[k][4-2*a]) begin
                  s = gr_ff[k][5-2*a] ? s - d[a] : s + d[a];
               end
            end
            dot_ff[k] <= s;
         end
      end
   end

   // fade stages 5..8: a=6t-15, b=rnd(t*a)+10, c=rnd(t*b); d=rnd(t*t), e=rnd(d*t)
   logic signed [MW-1:0] t5 [3];
   logic signed [MW-1:0] a5 [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         t5[a] = MW'({1'b0, frac4_ff[a]});
         a5[a] = MW'(6 * t5[a] - 15 * ONE_M);
      end
   end
   logic signed [MW-1:0] ta6 [3];
   logic signed [MW-1:0] tt6 [3];
   logic signed [MW-1:0] t6 [3];
   logic signed [MW-1:0] c7 [3];
   logic signed [MW-1:0] e7 [3];
   logic signed [MW-1:0] fade8 [3];
   logic [2:0][F:0] fade8_c, fade9_ff, fade10_ff, fade11_ff;
   logic signed [MW-1:0] b6 [3];

   genvar ga;
   generate
      for (ga = 0; ga < 3; ga++) begin : g_fade
         pn3d_fmul #(.FRAC_BITS(F), .A_W(MW), .B_W(MW), .P_W(MW)) u_ta (
            .clock(clock), .enable(adv), .a_in(t5[ga]), .b_in(a5[ga]), .p_out(ta6[ga]));
         pn3d_fmul #(.FRAC_BITS(F), .A_W(MW), .B_W(MW), .P_W(MW)) u_tt (
            .clock(clock), .enable(adv), .a_in(t5[ga]), .b_in(t5[ga]), .p_out(tt6[ga]));
         always_ff @(posedge clock) begin
            if (adv) begin
               t6[ga] <= t5[ga];
            end
         end
         assign b6[ga] = MW'(ta6[ga] + 10 * ONE_M);
         pn3d_fmul #(.FRAC_BITS(F), .A_W(MW), .B_W(MW), .P_W(MW)) u_c (
            .clock(clock), .enable(adv), .a_in(t6[ga]), .b_in(b6[ga]), .p_out(c7[ga]));
         pn3d_fmul #(.FRAC_BITS(F), .A_W(MW), .B_W(MW), .P_W(MW)) u_e (
            .clock(clock), .enable(adv), .a_in(tt6[ga]), .b_in(t6[ga]), .p_out(e7[ga]));
         pn3d_fmul #(.FRAC_BITS(F), .A_W(MW), .B_W(MW), .P_W(MW)) u_f (
            .clock(clock), .enable(adv), .a_in(e7[ga]), .b_in(c7[ga]), .p_out(fade8[ga]));
         // clamp to 0..ONE
         assign fade8_c[ga] = (fade8[ga] < 0) ? '0 :
                              (fade8[ga] > ONE_M) ? (F+1)'(1) << F : (F+1)'(fade8[ga]);
         always_ff @(posedge clock) begin
            if (adv) begin
               fade9_ff[ga]  <= fade8_c[ga];
               fade10_ff[ga] <= fade9_ff[ga];
               fade11_ff[ga] <= fade10_ff[ga];
            end
         end
      end
   endgenerate

   // delay dot products to line up with fade (stage 5 -> 8)
   logic signed [NW-1:0] dot6_ff [8];
   logic signed [NW-1:0] dot7_ff [8];
   logic signed [NW-1:0] dot8_ff [8];
   always_ff @(posedge clock) begin
      if (adv) begin
         dot6_ff <= dot_ff;
         dot7_ff <= dot6_ff;
         dot8_ff <= dot7_ff;
      end
   end

   // mix level x: stage 8 -> 9 (product) -> add
   localparam int DW = NW + 1;
   logic signed [DW-1:0] dx_diff [4];
   logic signed [DW-1:0] px9 [4];
   logic signed [NW-1:0] base9_ff [4];
   logic signed [DW-1:0] mx9 [4];
   logic signed [DW-1:0] dy_diff [2];
   logic signed [DW-1:0] py10 [2];
   logic signed [DW-1:0] base10_ff [2];
   logic signed [DW-1:0] my10 [2];
   logic signed [DW-1:0] dz_diff, pz11, base11_ff, r11;
   genvar gm;
   generate
      for (gm = 0; gm < 4; gm++) begin : g_mx
         assign dx_diff[gm] = DW'(dot8_ff[2*gm+1]) - DW'(dot8_ff[2*gm]);
         pn3d_fmul #(.FRAC_BITS(F), .A_W(DW), .B_W(F+2), .P_W(DW)) u_mx (
            .clock(clock), .enable(adv), .a_in(dx_diff[gm]),
            .b_in($signed({1'b0, fade9_ff[0]})), .p_out(px9[gm]));
         always_ff @(posedge clock) begin
            if (adv) begin
               base9_ff[gm] <= dot8_ff[2*gm];
            end
         end
         assign mx9[gm] = DW'(base9_ff[gm]) + px9[gm];
      end
      for (gm = 0; gm < 2; gm++) begin : g_my
         assign dy_diff[gm] = mx9[2*gm+1] - mx9[2*gm];
         pn3d_fmul #(.FRAC_BITS(F), .A_W(DW), .B_W(F+2), .P_W(DW)) u_my (
            .clock(clock), .enable(adv), .a_in(dy_diff[gm]),
            .b_in($signed({1'b0, fade10_ff[1]})), .p_out(py10[gm]));
         always_ff @(posedge clock) begin
            if (adv) begin
               base10_ff[gm] <= mx9[2*gm];
            end
         end
         assign my10[gm] = base10_ff[gm] + py10[gm];
      end
   endgenerate
   assign dz_diff = my10[1] - my10[0];
   pn3d_fmul #(.FRAC_BITS(F), .A_W(DW), .B_W(F+2), .P_W(DW)) u_mz (
      .clock(clock), .enable(adv), .a_in(dz_diff),
      .b_in($signed({1'b0, fade11_ff[2]})), .p_out(pz11));
   always_ff @(posedge clock) begin
      if (adv) begin
         base11_ff <= my10[0];
      end
   end
   assign r11 = base11_ff + pz11;

   // scale to Q.16, saturate, register (stage 12)
   localparam int SW = DW + 16;
   localparam int OUT_W_L = pn3d_pkg::OUT_W;
   localparam int SH_DN = (F > pn3d_pkg::OUT_FRAC) ? F - pn3d_pkg::OUT_FRAC : 0;
   localparam int SH_UP = (F < pn3d_pkg::OUT_FRAC) ? pn3d_pkg::OUT_FRAC - F : 0;
   localparam int SH_RND = (SH_DN > 0) ? SH_DN - 1 : 0;
   logic signed [SW-1:0] scaled;
   logic signed [OUT_W_L-1:0] sat;
   always_comb begin
      if (SH_DN > 0) begin
         scaled = (SW'(r11) + (SW'(1) <<< SH_RND)) >>> SH_DN;
      end else begin
         scaled = SW'(r11) <<< SH_UP;
      end
      if (scaled > SW'(524287)) sat = 20'sd524287;
      else if (scaled < -SW'(524288)) sat = -20'sd524288;
      else sat = OUT_W_L'(scaled);
   end
   logic signed [OUT_W_L-1:0] out12_ff, out13_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out12_ff <= sat;
         out13_ff <= out12_ff;
      end
   end

   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = {4'b0, out13_ff};
endmodule

>>> src/pn3d_checker.sv
// Port-level checker for the Perlin noise block, bound to the top level.
// Depends on perlin_noise_3d_macros.svh.
`include "perlin_noise_3d_macros.svh"
module pn3d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   // held result stays put until taken
   `PN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response dropped or changed under stall")
   // input is open whenever output is empty
   `PN_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "request blocked with empty output")
   // pad bits are zero
   `PN_ASSERT_IMPL(a_pad, clock, reset, rsp_tvalid, rsp_tdata[23:20] == 4'b0, "pad bits set")
   // no output right after reset
   `PN_ASSERT_NEXT(a_reset, clock, 1'b0, reset, !rsp_tvalid, "response valid after reset")
endmodule

bind perlin_noise_3d pn3d_checker u_pn3d_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

>>> sim/tb_perlin_noise_3d.sv
// Testbench for perlin_noise_3d: streams 3D points in, predicts each noise sample
// with its own fixed-point model, and checks the samples in order.
// Depends on the RTL top perlin_noise_3d (and pn3d_pkg through it).
`timescale 1ns / 1ps

class noise_scoreboard;
   logic [19:0] pending_noise[$];
   int          error_count;

   function void note_request(logic [19:0] noise);
      pending_noise.push_back(noise);
   endfunction

   function void check_response(logic [23:0] data);
      logic [19:0] want;
      if (pending_noise.size() == 0) begin
         report($sformatf("unexpected response %h", data));
         return;
      end
      want = pending_noise.pop_front();
      if (data[19:0] !== want)
         report($sformatf("noise_value got %h want %h", data[19:0], want));
      if (data[23:20] !== 4'd0)
         report($sformatf("pad bits not zero: %h", data[23:20]));
   endfunction

   function void report(string msg);
      error_count++;
      $display("ERROR: %s", msg);
   endfunction
endclass

module tb_perlin_noise_3d;
   localparam int FRAC = 16;
   localparam int PERIOD = 256;
   localparam longint ONE = 64'sd1 <<< FRAC;
   localparam int LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   noise_scoreboard board;
   int  cycle_count = 0;
   bit  quiet_phase = 1'b0;
   bit  sink_on = 1'b0;

   byte unsigned perm_table[256] = '{
      151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,140,36,103,30,69,142,8,99,37,
      240,21,10,23,190,6,148,247,120,234,75,0,26,197,62,94,252,219,203,117,35,11,32,57,177,
      33,88,237,149,56,87,174,20,125,136,171,168,68,175,74,165,71,134,139,48,27,166,77,146,
      158,231,83,111,229,122,60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,65,25,
      63,161,1,216,80,73,209,76,132,187,208,89,18,169,200,196,135,130,116,188,159,86,164,100,
      109,198,173,186,3,64,52,217,226,250,124,123,5,202,38,147,118,126,255,82,85,212,207,206,
      59,227,47,16,58,17,182,189,28,42,223,183,170,213,119,248,152,2,44,154,163,70,221,153,
      101,155,167,43,172,9,129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,218,
      246,97,228,251,34,242,193,238,210,144,12,191,179,162,241,81,51,145,235,249,14,239,107,
      49,192,214,31,181,199,106,157,184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,
      93,222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180};
   int grad_x[12] = '{1,-1,1,-1,1,-1,1,-1,0,0,0,0};
   int grad_y[12] = '{1,1,-1,-1,0,0,0,0,1,-1,1,-1};
   int grad_z[12] = '{0,0,0,0,1,1,-1,-1,1,1,-1,-1};

   perlin_noise_3d u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #10 clock = ~clock;

   // fixed-point product, rounded to nearest with ties up (arithmetic shift floors)
   function automatic longint fx_mul(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint fade_weight(longint t);
      longint b, c, e, r;
      b = fx_mul(t, 6 * t - 15 * ONE) + 10 * ONE;
      c = fx_mul(t, b);
      e = fx_mul(fx_mul(t, t), t);
      r = fx_mul(e, c);
      if (r < 0) r = 0;
      if (r > ONE) r = ONE;
      return r;
   endfunction

   function automatic longint blend(longint a, longint b, longint t);
      return a + fx_mul(b - a, t);
   endfunction

   function automatic int perm_at(int idx);
      return perm_table[idx & 255];
   endfunction

   // predict the noise sample for one point
   function automatic logic [19:0] predict_noise(logic [31:0] cx, logic [31:0] cy,
                                                 logic [31:0] cz);
      longint v[3], fl, fr[3], n[8], f[3], mx[4], r;
      int cell_idx[3], h, g, bx, by, bz;
      v[0] = longint'(signed'(cx));
      v[1] = longint'(signed'(cy));
      v[2] = longint'(signed'(cz));
      for (int i = 0; i < 3; i++) begin
         fl = v[i] >>> FRAC;
         fr[i] = v[i] - fl * ONE;
         cell_idx[i] = int'(((fl % PERIOD) + PERIOD) % PERIOD);
      end
      for (int k = 0; k < 8; k++) begin
         bx = k & 1; by = (k >> 1) & 1; bz = (k >> 2) & 1;
         h = perm_at(cell_idx[2] + bz);
         h = perm_at(cell_idx[1] + by + h);
         h = perm_at(cell_idx[0] + bx + h);
         g = h % 12;
         n[k] = grad_x[g] * (fr[0] - bx * ONE) + grad_y[g] * (fr[1] - by * ONE)
              + grad_z[g] * (fr[2] - bz * ONE);
      end
      for (int i = 0; i < 3; i++) f[i] = fade_weight(fr[i]);
      for (int j = 0; j < 4; j++) mx[j] = blend(n[2*j], n[2*j+1], f[0]);
      r = blend(blend(mx[0], mx[1], f[1]), blend(mx[2], mx[3], f[1]), f[2]);
      if (r > 524287) r = 524287;
      if (r < -524288) r = -524288;
      return r[19:0];
   endfunction

   // offer one request, holding it until accepted, with random gaps before it
   task automatic send_point(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      int gap;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {cz, cy, cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(predict_noise(cx, cy, cz));
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         2: return {16'($urandom()), 16'h0000};
         3: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
         default: return 32'($signed($urandom_range(0, 1048575)) - 524288);
      endcase
   endfunction

   // sink side: random stall bursts until the quiet phase
   always @(posedge clock) begin
      int stall;
      if (sink_on) begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 11);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         end
         rsp_tready <= 1'b1;
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("perlin_noise_3d test failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] edge_vals[10];
      board = new();
      edge_vals = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_8000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0100_0000, 32'h0000_0001};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      sink_on <= 1'b1;
      @(posedge clock);
      // corners, integers, zero, cell wrap and extremes
      for (int i = 0; i < 10; i++)
         send_point(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10]);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'h00FF_8000, 32'hFF00_8000, 32'h0000_8000);
      for (int i = 0; i < 650; i++) begin
         if (i == 520) quiet_phase = 1'b1;
         send_point(random_coord(), random_coord(), random_coord());
      end
      req_tvalid <= 1'b0;
      while (board.pending_noise.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.error_count == 0)
         $display("perlin_noise_3d test passed");
      else
         $display("perlin_noise_3d test failed");
      $finish;
   end
endmodule
